// ===== design/assert_macros.svh =====
// Assertion macros used by the top design file of the logarithm pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lnser_pkg.sv =====
// Package with the types and constants shared by the logarithm pipeline.
package lnser_pkg;

    // Number of terms of the expansion around two.
    localparam int HIGH_TERMS = 6;

    // ln 2 with 62 fractional bits, rounded to the working precision where used.
    localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;

    // Control that travels with each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic hi;
    } t_ctl;

endpackage

// ===== design/lnser_in_if.sv =====
// Stream interface carrying the input value of the logarithm pipeline.
interface lnser_in_if #(
    parameter int WIDTH = 24
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value_q;

    modport source (output valid, output value_q, input ready);
    modport sink   (input valid, input value_q, output ready);
endinterface

// ===== design/lnser_out_if.sv =====
// Stream interface carrying the logarithm result.
interface lnser_out_if #(
    parameter int WIDTH = 25
) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] ln_q;

    modport source (output valid, output ln_q, input ready);
    modport sink   (input valid, input ln_q, output ready);
endinterface

// ===== design/lnser_front.sv =====
// Front stage: clamps the input, picks the branch and forms the series base.
module lnser_front #(
    parameter int FRAC_BITS = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [FRAC_BITS:0]      i_value,
    output logic                    o_ready,
    output lnser_pkg::t_ctl         o_ctl,
    output logic [FRAC_BITS-1:0]    o_base,
    output logic [FRAC_BITS-1:0]    o_pow,
    output logic [FRAC_BITS-1:0]    o_quot,
    output logic signed [FRAC_BITS+2:0] o_acc,
    input  logic                    i_ready
);
    import lnser_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = F + 3;
    localparam logic [63:0] LN2_ROUND = (LN2_Q62 + (64'd1 << (61 - F))) >> (62 - F);

    logic [F:0]          value_c;
    logic [F:0]          m_wide;
    t_ctl                n_ctl;
    logic [F-1:0]        n_base;
    logic signed [AW-1:0] n_acc;
    t_ctl                r_ctl;
    logic [F-1:0]        r_base;
    logic signed [AW-1:0] r_acc;

    // A value below one is treated as exactly one.
    assign value_c = i_value[F] ? i_value : {1'b1, {F{1'b0}}};

    // With the top bit set, the value reaches 1.5 exactly when the next bit is set.
    assign m_wide     = {1'b1, {F{1'b0}}} - {1'b0, value_c[F-1:0]};
    assign n_ctl.valid = i_valid;
    assign n_ctl.hi    = value_c[F-1];
    assign n_base = n_ctl.hi ? m_wide[F-1:0] : value_c[F-1:0];
    assign n_acc  = n_ctl.hi ? $signed({3'b000, LN2_ROUND[F-1:0]}) : '0;

    assign o_ready = !r_ctl.valid || i_ready;

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= n_ctl;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_base <= n_base;
            r_acc  <= n_acc;
        end
    end

    // The first power equals the base and no term is pending yet.
    assign o_ctl  = r_ctl;
    assign o_base = r_base;
    assign o_pow  = r_base;
    assign o_quot = '0;
    assign o_acc  = r_acc;
endmodule

// ===== design/lnser_term.sv =====
// Series stage: next power, quotient of this power and sum of the previous term.
module lnser_term #(
    parameter int FRAC_BITS = 23,
    parameter int K         = 1,
    parameter int LOW_TERMS = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lnser_pkg::t_ctl         i_ctl,
    input  logic [FRAC_BITS-1:0]    i_base,
    input  logic [FRAC_BITS-1:0]    i_pow,
    input  logic [FRAC_BITS-1:0]    i_quot,
    input  logic signed [FRAC_BITS+2:0] i_acc,
    output logic                    o_ready,
    output lnser_pkg::t_ctl         o_ctl,
    output logic [FRAC_BITS-1:0]    o_base,
    output logic [FRAC_BITS-1:0]    o_pow,
    output logic [FRAC_BITS-1:0]    o_quot,
    output logic signed [FRAC_BITS+2:0] o_acc,
    input  logic                    i_ready
);
    import lnser_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = F + 3;
    localparam bit LOW_USE  = (K <= LOW_TERMS);
    localparam bit HIGH_USE = (K <= HIGH_TERMS);
    // The previous term is added in the low branch when its index is odd.
    localparam bit PREV_ADD = (((K - 1) % 2) == 1);

    logic [2*F-1:0]       pow_prod;
    logic [F-1:0]         num;
    logic [F-1:0]         quot_raw;
    logic                 term_used;
    logic signed [AW-1:0] prev_term;
    t_ctl                 r_ctl;
    logic [F-1:0]         r_base;
    logic [F-1:0]         r_pow;
    logic [F-1:0]         r_quot;
    logic signed [AW-1:0] r_acc;
    logic [F-1:0]         n_pow;
    logic [F-1:0]         n_quot;
    logic signed [AW-1:0] n_acc;

    // Next power of the base.
    assign pow_prod = i_pow * i_base;
    assign n_pow    = pow_prod[2*F-1:F];

    // The expansion around two also divides by two to the power of the term index.
    assign num = i_ctl.hi ? (i_pow >> K) : i_pow;

    // Division by the term index as a multiplication by a rounded-up reciprocal.
    // The numerator stays at or below half of one, so the quotient is exact.
    generate
        if (K == 1) begin : g_div_one
            assign quot_raw = num;
        end else begin : g_div_const
            localparam int S  = F + 3;
            localparam logic [S-1:0] RECIP =
                S'(((64'd1 << S) + 64'(K) - 64'd1) / 64'(K));
            logic [F+S-1:0] div_prod;
            assign div_prod = num * RECIP;
            assign quot_raw = div_prod[F+S-1:S];
        end
    endgenerate

    assign term_used = i_ctl.hi ? HIGH_USE : LOW_USE;
    assign n_quot    = term_used ? quot_raw : '0;

    // Accumulate the term that the previous stage divided out.
    assign prev_term = $signed({3'b000, i_quot});
    assign n_acc = (i_ctl.hi || !PREV_ADD) ? (i_acc - prev_term) : (i_acc + prev_term);

    assign o_ready = !r_ctl.valid || i_ready;

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_base <= i_base;
            r_pow  <= n_pow;
            r_quot <= n_quot;
            r_acc  <= n_acc;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_base = r_base;
    assign o_pow  = r_pow;
    assign o_quot = r_quot;
    assign o_acc  = r_acc;
endmodule

// ===== design/lnser_back.sv =====
// Back stage: saturates the sum to the result width and holds the output register.
module lnser_back #(
    parameter int FRAC_BITS = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lnser_pkg::t_ctl         i_ctl,
    input  logic signed [FRAC_BITS+2:0] i_acc,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic signed [FRAC_BITS+1:0] o_ln,
    input  logic                    i_ready
);
    import lnser_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int OW = F + 2;

    logic                 r_valid;
    logic signed [OW-1:0] r_ln;
    logic signed [OW-1:0] n_ln;

    // Clip to the signed result range when the two top bits disagree.
    always_comb begin
        if (i_acc[F+2] == i_acc[F+1]) begin
            n_ln = i_acc[OW-1:0];
        end else if (i_acc[F+2]) begin
            n_ln = {1'b1, {(OW-1){1'b0}}};
        end else begin
            n_ln = {1'b0, {(OW-1){1'b1}}};
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Output data register.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ln <= n_ln;
        end
    end

    assign o_valid = r_valid;
    assign o_ln    = r_ln;
endmodule

// ===== design/ln_series_one_to_two.sv =====
// An item passes the front, term and back stage registers from input transfer to result.
// Throughput: one item per cycle unless the output stalls. Each term stage holds one
// next-power multiplier and, past the first, one constant-reciprocal term multiplier.
// Each stage advances when its successor is empty or moving, so bubbles close up.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
module ln_series_one_to_two #(
    parameter int LOW_TERMS = 5,
    parameter int FRAC_BITS = 23
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lnser_in_if.sink    i_in,
    lnser_out_if.source o_out
);
    import lnser_pkg::*;

    `include "assert_macros.svh"

    localparam int F  = FRAC_BITS;
    localparam int AW = F + 3;
    localparam int N  = (LOW_TERMS > HIGH_TERMS) ? LOW_TERMS : HIGH_TERMS;

    t_ctl                 link_ctl   [0:N+1];
    logic [F-1:0]         link_base  [0:N+1];
    logic [F-1:0]         link_pow   [0:N+1];
    logic [F-1:0]         link_quot  [0:N+1];
    logic signed [AW-1:0] link_acc   [0:N+1];
    logic                 link_ready [0:N+1];

    // Branch selection and base.
    lnser_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_value (i_in.value_q),
        .o_ready (i_in.ready),
        .o_ctl   (link_ctl[0]),
        .o_base  (link_base[0]),
        .o_pow   (link_pow[0]),
        .o_quot  (link_quot[0]),
        .o_acc   (link_acc[0]),
        .i_ready (link_ready[0])
    );

    // One stage per term plus one that adds the last term.
    generate
        for (genvar k = 1; k <= N + 1; k++) begin : g_term
            lnser_term #(
                .FRAC_BITS (FRAC_BITS),
                .K         (k),
                .LOW_TERMS (LOW_TERMS)
            ) u_term (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (link_ctl[k-1]),
                .i_base  (link_base[k-1]),
                .i_pow   (link_pow[k-1]),
                .i_quot  (link_quot[k-1]),
                .i_acc   (link_acc[k-1]),
                .o_ready (link_ready[k-1]),
                .o_ctl   (link_ctl[k]),
                .o_base  (link_base[k]),
                .o_pow   (link_pow[k]),
                .o_quot  (link_quot[k]),
                .o_acc   (link_acc[k]),
                .i_ready (link_ready[k])
            );
        end
    endgenerate

    // Saturation and output register.
    lnser_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (link_ctl[N+1]),
        .i_acc   (link_acc[N+1]),
        .o_ready (link_ready[N+1]),
        .o_valid (o_out.valid),
        .o_ln    (o_out.ln_q),
        .i_ready (o_out.ready)
    );

    // The pipeline is empty right after reset.
    `ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n) |-> !o_out.valid, "result valid after reset")
    // An input transfer always lands in the front stage.
    `ASSERT_CLK(a_front_loaded, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> link_ctl[0].valid, "input transfer lost")
    // Both branches give a logarithm between zero and ln 2, never a negative one.
    `ASSERT_CLK(a_result_sign, i_clk, i_rst_n, o_out.valid |-> !o_out.ln_q[F+1], "negative logarithm")
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Q1.23 natural logarithm pipeline.
module tb;
    import lnser_pkg::*;

    localparam int          LOW_TERMS    = 5;
    localparam int          FRAC_BITS    = 23;
    localparam int          IN_W         = FRAC_BITS + 1;
    localparam int          OUT_W        = FRAC_BITS + 2;
    localparam int          LATENCY      = (LOW_TERMS > HIGH_TERMS ? LOW_TERMS : HIGH_TERMS) + 3;
    localparam int          DRAIN_CYCLES = 2 * LATENCY + 4;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          RANDOM_ITEMS = 1000;
    localparam logic [63:0] ONE_Q        = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF_UP_Q    = 3 * (ONE_Q >> 1);
    localparam logic [63:0] LN2_Q        = (LN2_Q62 + (64'd1 << (61 - FRAC_BITS)))
                                           >> (62 - FRAC_BITS);
    localparam longint      OUT_MAX      = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint      OUT_MIN      = -OUT_MAX - 1;

    logic clk;
    logic rst_n;

    lnser_in_if  #(.WIDTH(IN_W))  in_if ();
    lnser_out_if #(.WIDTH(OUT_W)) out_if ();

    ln_series_one_to_two #(
        .LOW_TERMS(LOW_TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // Logarithms still owed by the pipeline, oldest first.
    logic signed [OUT_W-1:0] ln_expected[$];

    int n_errors;
    int n_sent;
    int n_checked;
    int n_clamped;
    int n_low;
    int n_high;
    int n_cycles;
    bit hold_request;

    // Expected logarithm of one input value, in the block's fixed-point arithmetic.
    function automatic logic signed [OUT_W-1:0] predict_ln(input logic [IN_W-1:0] value);
        logic [63:0] v;
        logic [63:0] base;
        logic [63:0] pw;
        longint      acc;
        v  = 64'(value);
        pw = ONE_Q;
        if (v < ONE_Q) begin
            v = ONE_Q;
        end
        if (v < HALF_UP_Q) begin
            // Alternating series of ln(1 + x) with divisors 1, 2, 3 and so on.
            base = v - ONE_Q;
            acc  = 0;
            for (int k = 1; k <= LOW_TERMS; k++) begin
                pw = (pw * base) >> FRAC_BITS;
                if (k % 2 == 1) begin
                    acc += longint'(pw / 64'(k));
                end else begin
                    acc -= longint'(pw / 64'(k));
                end
            end
        end else begin
            // Expansion around two: every term is m^k / (k * 2^k) taken off ln 2.
            base = 2 * ONE_Q - v;
            acc  = longint'(LN2_Q);
            for (int k = 1; k <= HIGH_TERMS; k++) begin
                pw  = (pw * base) >> FRAC_BITS;
                acc -= longint'(pw / (64'(k) << k));
            end
        end
        if (acc > OUT_MAX) begin
            acc = OUT_MAX;
        end
        if (acc < OUT_MIN) begin
            acc = OUT_MIN;
        end
        return acc[OUT_W-1:0];
    endfunction

    // Offers one value and records its logarithm once the transfer happens.
    task automatic send_value(input logic [IN_W-1:0] value);
        @(negedge clk);
        in_if.valid   = 1'b1;
        in_if.value_q = value;
        do @(posedge clk); while (!in_if.ready);
        ln_expected.push_back(predict_ln(value));
        n_sent++;
        if (value < ONE_Q[IN_W-1:0]) begin
            n_clamped++;
        end else if (value < HALF_UP_Q[IN_W-1:0]) begin
            n_low++;
        end else begin
            n_high++;
        end
    endtask

    // Leaves the input idle for the given number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Smallest, largest and alternating bit patterns among values of one and above.
    task automatic test_field_extremes();
        send_value(24'h800000);
        send_value(24'h800001);
        send_value(24'hFFFFFF);
        send_value(24'hFFFFFE);
        send_value(24'hAAAAAA);
        send_value(24'hD55555);
        send_value(24'h955555);
        pause_sender(3);
    endtask

    // Values with the top bit clear are treated as exactly one.
    task automatic test_below_one();
        send_value(24'h000000);
        send_value(24'h000001);
        send_value(24'h400000);
        send_value(24'h7FFFFF);
        send_value(24'h555555);
        pause_sender(2);
    endtask

    // Either side of 1.5, where the series gives way to the expansion around two.
    task automatic test_branch_boundary();
        send_value(24'hBFFFFF);
        send_value(24'hC00000);
        send_value(24'hC00001);
        send_value(24'hBFFFFE);
        send_value(24'hC00000);
        send_value(24'hBFFFFF);
        pause_sender(4);
    endtask

    // The receiver holds off while values keep coming, so the pipeline fills and stalls.
    task automatic test_full_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 4 * LATENCY; i++) begin
            send_value(24'(ONE_Q + $urandom_range(0, int'(ONE_Q) - 1)));
        end
        pause_sender(1);
        wait (!hold_request);
    endtask

    // Random values in bursts; mostly in range, some below one, some hugging 1.5.
    task automatic test_random_stream();
        int               burst;
        int               sel;
        logic [IN_W-1:0]  value;
        int               sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    value = 24'($urandom_range(int'(ONE_Q), 2 * int'(ONE_Q) - 1));
                end else if (sel < 90) begin
                    value = 24'($urandom_range(0, int'(ONE_Q) - 1));
                end else begin
                    value = 24'(int'(HALF_UP_Q) + $urandom_range(0, 64) - 32);
                end
                send_value(value);
                sent++;
            end
            // Roughly a third of bursts run straight into the next one.
            if ($urandom_range(0, 2) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
        pause_sender(1);
    endtask

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output stall pattern: modes change at random, with a long hold on request.
    initial begin : result_ready_pattern
        int mode;
        int mode_left;
        int phase;
        out_if.ready = 1'b0;
        mode         = 0;
        mode_left    = 0;
        phase        = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: begin
                        out_if.ready = 1'b1;
                    end
                    1: begin
                        out_if.ready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        out_if.ready = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        out_if.ready = (phase % 3 != 0);
                    end
                endcase
            end
        end
    end

    // Compares each result transfer with the oldest outstanding logarithm.
    initial begin : result_check
        logic signed [OUT_W-1:0] want;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                if (ln_expected.size() == 0) begin
                    $display("%0t: result with none outstanding: expected none, actual ln_q=%h",
                             $time, out_if.ln_q);
                    n_errors++;
                end else begin
                    want = ln_expected.pop_front();
                    n_checked++;
                    if (out_if.ln_q !== want) begin
                        $display("%0t: ln_q mismatch: expected %h, actual %h",
                                 $time, want, out_if.ln_q);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on the total number of cycles.
    initial begin : cycle_watchdog
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            n_cycles++;
        end
        $display("** ln_series_one_to_two: FAILED **");
        $finish;
    end

    // Test sequence.
    initial begin : test_sequence
        n_errors      = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_clamped     = 0;
        n_low         = 0;
        n_high        = 0;
        hold_request  = 1'b0;
        in_if.valid   = 1'b0;
        in_if.value_q = '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_below_one();
        test_branch_boundary();
        test_full_stall();
        test_random_stream();

        // Let every outstanding result arrive, then allow for stray extra transfers.
        while (ln_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d values (%0d below one, %0d series branch, %0d expansion branch),",
                 n_sent, n_clamped, n_low, n_high);
        $display("%0d results checked under random stalls and one long output hold.",
                 n_checked);
        if (n_errors == 0) begin
            $display("** ln_series_one_to_two: PASSED **");
        end else begin
            $display("** ln_series_one_to_two: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lnser_pkg.sv
design/lnser_in_if.sv
design/lnser_out_if.sv
design/lnser_front.sv
design/lnser_term.sv
design/lnser_back.sv
design/ln_series_one_to_two.sv
tb/tb.sv
